// ----- rtl/tdadsr_pkg.sv -----
// ----------------------------------------------------------------------------
// tdadsr_pkg : shared types and constants for the table-driven envelope
// Codes, stream field widths, control structs and the state encodings used
// by the engine, the serial divider and the port checker.
// ----------------------------------------------------------------------------
package tdadsr_pkg;

	// table geometry
	localparam int TABLE_DEPTH_DEF = 32;

	// stream widths
	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_DATA_W  = 31;

	// item kinds carried on tuser
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_START = 2'd2;

	// register indexes
	localparam logic [1:0] CFG_UPF     = 2'd0;
	localparam logic [1:0] CFG_SUSTAIN = 2'd1;
	localparam logic [1:0] CFG_FADE    = 2'd2;

	// special entry delays
	localparam logic [15:0] DLY_DISABLE = 16'h0000;
	localparam logic [15:0] DLY_HANG    = 16'hFFFF;
	localparam logic [15:0] DLY_GOTO    = 16'hFFFE;
	localparam logic [15:0] DLY_RESTART = 16'hFFFD;

	// pending request bits
	localparam int REQ_HANG    = 0;
	localparam int REQ_DECAY   = 1;
	localparam int REQ_RELEASE = 2;

	// target = round(arg^2 * 2^30 / 32767^2)
	localparam logic [29:0] TGT_DENOM = 30'd1073676289;
	localparam logic [29:0] TGT_BIAS  = 30'd536838144;

	localparam logic [16:0] SUS_TICKS = 17'd128;

	// divider step counts
	localparam logic [5:0] STEPS_TGT  = 6'd31;
	localparam logic [5:0] STEPS_RAMP = 6'd32;
	localparam logic [5:0] STEPS_GOTO = 6'd16;

	typedef enum logic [3:0] {
		PH_DISABLED = 4'd0,
		PH_INITIAL  = 4'd1,
		PH_START    = 4'd2,
		PH_LOOP     = 4'd3,
		PH_FADE     = 4'd4,
		PH_HANG     = 4'd5,
		PH_DECAY    = 4'd6,
		PH_RELEASE  = 4'd7,
		PH_SUSTAIN  = 4'd8
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_READ,
		ST_LOAD,
		ST_GOTO,
		ST_TGT_GO,
		ST_TGT,
		ST_RAMP_GO,
		ST_RAMP,
		ST_FADE,
		ST_DR,
		ST_SUS,
		ST_FINISH,
		ST_EMIT
	} st_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [4:0]         entry_index;
		logic signed [15:0] entry_delay;
		logic signed [15:0] entry_arg;
		logic               hang_request;
		logic               decay_request;
		logic               release_request;
	} item_t;

	typedef struct packed {
		logic [3:0]  updates_per_frame;
		logic [30:0] sustain_level;
		logic [30:0] fade_out_step;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] level;
		logic [3:0]  phase;
	} res_t;

	typedef struct packed {
		logic        start;
		logic [30:0] rem;
		logic [31:0] bits;
		logic [29:0] divisor;
		logic [5:0]  steps;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [30:0] rem;
	} div_rsp_t;

endpackage

// ----- rtl/tdadsr_div.sv -----
// ----------------------------------------------------------------------------
// tdadsr_div : bit-serial restoring divider
// One quotient bit per cycle; dividend bits shift in MSB first while the
// quotient shifts into the same register from the bottom.
// ----------------------------------------------------------------------------
module tdadsr_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tdadsr_pkg::div_req_t req,
	output tdadsr_pkg::div_rsp_t rsp
);

	logic [31:0] sh_q;
	logic [30:0] rem_q;
	logic [29:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [31:0] trial;
	logic [31:0] diff;
	logic        ge;

	assign trial = {rem_q, sh_q[31]};
	assign diff  = trial - {2'b00, dvs_q};
	assign ge    = trial >= {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q  <= req.bits;
			rem_q <= req.rem;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			sh_q  <= {sh_q[30:0], ge};
			rem_q <= ge ? diff[30:0] : trial[30:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sh_q;
	assign rsp.rem  = rem_q;

endmodule

// ----- rtl/tdadsr_engine.sv -----
// ----------------------------------------------------------------------------
// tdadsr_engine : envelope sequencer with entry table
// Holds the envelope state and the entry memory, walks one tick per item and
// hands the divisions to the serial divider.
// ----------------------------------------------------------------------------
module tdadsr_engine #(
	parameter int TABLE_DEPTH = tdadsr_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tdadsr_pkg::item_t item,
	input  logic              accept,
	output logic              ready,
	input  tdadsr_pkg::cfg_t  cfg,
	input  logic              out_free,
	output tdadsr_pkg::res_t  res
);

	localparam int AW = $clog2(TABLE_DEPTH);

	tdadsr_pkg::st_t    st_q, st_d;
	tdadsr_pkg::phase_t phase_q;

	logic [AW-1:0]      pos_q;
	logic [16:0]        ticks_q;
	logic signed [31:0] level_q;
	logic signed [31:0] ramp_q;
	logic [2:0]         pend_q;
	logic               zero_q;

	logic [31:0] rd_q;
	logic [16:0] n_q;
	logic [30:0] sq_q;
	logic [32:0] num_q;
	logic        neg_q;

	logic [31:0] tbl_mem [TABLE_DEPTH];

	tdadsr_pkg::div_req_t div_req;
	tdadsr_pkg::div_rsp_t div_rsp;

	function automatic logic [31:0] sat32(input logic [32:0] v);
		if (v[32] != v[31])
			return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return v[31:0];
	endfunction

	// entry decode
	logic [15:0]        ent_dly;
	logic signed [15:0] ent_arg;
	logic               ent_disable, ent_hang, ent_goto, ent_restart, ent_normal;
	logic [14:0]        d_eff;
	logic [18:0]        prod;
	logic [16:0]        n_raw, n_new;
	logic signed [31:0] sq_full;

	assign ent_dly     = rd_q[15:0];
	assign ent_arg     = rd_q[31:16];
	assign ent_disable = ent_dly == tdadsr_pkg::DLY_DISABLE;
	assign ent_hang    = ent_dly == tdadsr_pkg::DLY_HANG;
	assign ent_goto    = ent_dly == tdadsr_pkg::DLY_GOTO;
	assign ent_restart = ent_dly == tdadsr_pkg::DLY_RESTART;
	assign ent_normal  = !(ent_disable || ent_hang || ent_goto || ent_restart);
	// other negative delays count as one tick
	assign d_eff       = ent_dly[15] ? 15'd1 : ent_dly[14:0];
	assign prod        = 19'(d_eff) * 19'(cfg.updates_per_frame);
	assign n_raw       = (d_eff >= 15'd4) ? prod[18:2] : 17'(d_eff);
	assign n_new       = (n_raw == 17'd0) ? 17'd1 : n_raw;
	assign sq_full     = ent_arg * ent_arg;

	// datapath
	logic [31:0] fade_lv, dr_lv, ramp_new, q;
	logic [32:0] dr_diff, tgt_num, num_mag;
	logic        sus_hit;
	logic [16:0] ticks_dec;
	logic [AW-1:0] pos_next;
	logic [15:0] lvl_out;

	assign fade_lv   = sat32({level_q[31], level_q} + {ramp_q[31], ramp_q});
	assign dr_diff   = {level_q[31], level_q} - {2'b00, cfg.fade_out_step};
	assign dr_lv     = sat32(dr_diff);
	assign sus_hit   = $signed({dr_lv[31], dr_lv}) < $signed({2'b00, cfg.sustain_level});
	assign ticks_dec = ticks_q - 17'd1;
	assign tgt_num   = {2'b00, div_rsp.quot[30:0]} - {level_q[31], level_q};
	assign num_mag   = num_q[32] ? (33'd0 - num_q) : num_q;
	assign q         = div_rsp.quot;
	assign ramp_new  = neg_q ? (32'd0 - q) : (q[31] ? 32'h7FFF_FFFF : q);
	assign pos_next  = (pos_q == AW'(TABLE_DEPTH - 1)) ? '0 : pos_q + 1'b1;

	always_comb begin
		if (level_q[31])
			lvl_out = 16'd0;
		else if (level_q[30:0] > 31'h4000_0000)
			lvl_out = 16'h8000;
		else
			lvl_out = level_q[30:15];
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			tdadsr_pkg::ST_IDLE:
				if (accept && item.action == tdadsr_pkg::ACT_TICK)
					st_d = (phase_q == tdadsr_pkg::PH_DISABLED) ?
						tdadsr_pkg::ST_EMIT : tdadsr_pkg::ST_STEP;
			tdadsr_pkg::ST_STEP: begin
				case (phase_q)
					tdadsr_pkg::PH_INITIAL:
						st_d = pend_q[tdadsr_pkg::REQ_HANG] ?
							tdadsr_pkg::ST_FINISH : tdadsr_pkg::ST_READ;
					tdadsr_pkg::PH_START, tdadsr_pkg::PH_LOOP:
						st_d = tdadsr_pkg::ST_READ;
					tdadsr_pkg::PH_FADE: st_d = tdadsr_pkg::ST_FADE;
					tdadsr_pkg::PH_DECAY, tdadsr_pkg::PH_RELEASE:
						st_d = tdadsr_pkg::ST_DR;
					tdadsr_pkg::PH_SUSTAIN: st_d = tdadsr_pkg::ST_SUS;
					default: st_d = tdadsr_pkg::ST_FINISH;
				endcase
			end
			tdadsr_pkg::ST_READ: st_d = tdadsr_pkg::ST_LOAD;
			tdadsr_pkg::ST_LOAD: begin
				if (ent_goto)
					st_d = tdadsr_pkg::ST_GOTO;
				else if (ent_normal)
					st_d = tdadsr_pkg::ST_TGT_GO;
				else
					st_d = tdadsr_pkg::ST_FINISH;
			end
			tdadsr_pkg::ST_GOTO: if (div_rsp.done) st_d = tdadsr_pkg::ST_FINISH;
			tdadsr_pkg::ST_TGT_GO: st_d = tdadsr_pkg::ST_TGT;
			tdadsr_pkg::ST_TGT: if (div_rsp.done) st_d = tdadsr_pkg::ST_RAMP_GO;
			tdadsr_pkg::ST_RAMP_GO: st_d = tdadsr_pkg::ST_RAMP;
			tdadsr_pkg::ST_RAMP: if (div_rsp.done) st_d = tdadsr_pkg::ST_FADE;
			tdadsr_pkg::ST_FADE, tdadsr_pkg::ST_DR, tdadsr_pkg::ST_SUS:
				st_d = tdadsr_pkg::ST_FINISH;
			tdadsr_pkg::ST_FINISH: st_d = tdadsr_pkg::ST_EMIT;
			tdadsr_pkg::ST_EMIT: if (out_free) st_d = tdadsr_pkg::ST_IDLE;
			default: st_d = tdadsr_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ready   = st_q == tdadsr_pkg::ST_IDLE;
		div_req = '0;
		case (st_q)
			tdadsr_pkg::ST_LOAD: begin
				if (ent_goto) begin
					div_req.start   = 1'b1;
					div_req.bits    = {rd_q[31:16], 16'h0000};
					div_req.divisor = 30'(TABLE_DEPTH);
					div_req.steps   = tdadsr_pkg::STEPS_GOTO;
				end
			end
			tdadsr_pkg::ST_TGT_GO: begin
				div_req.start   = 1'b1;
				div_req.rem     = {1'b0, sq_q[30:1]};
				div_req.bits    = {sq_q[0], tdadsr_pkg::TGT_BIAS, 1'b0};
				div_req.divisor = tdadsr_pkg::TGT_DENOM;
				div_req.steps   = tdadsr_pkg::STEPS_TGT;
			end
			tdadsr_pkg::ST_RAMP_GO: begin
				div_req.start   = 1'b1;
				div_req.bits    = num_mag[31:0];
				div_req.divisor = {13'd0, n_q};
				div_req.steps   = tdadsr_pkg::STEPS_RAMP;
			end
			default: ;
		endcase
		res.valid = (st_q == tdadsr_pkg::ST_EMIT) && out_free;
		res.level = zero_q ? 16'd0 : lvl_out;
		res.phase = phase_q;
	end

	// envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= tdadsr_pkg::ST_IDLE;
			phase_q <= tdadsr_pkg::PH_DISABLED;
			pos_q   <= '0;
			ticks_q <= '0;
			level_q <= '0;
			ramp_q  <= '0;
			pend_q  <= '0;
			zero_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				tdadsr_pkg::ST_IDLE: begin
					if (accept) begin
						case (item.action)
							tdadsr_pkg::ACT_START: begin
								phase_q <= tdadsr_pkg::PH_INITIAL;
								pend_q  <= {2'b00, item.hang_request};
							end
							tdadsr_pkg::ACT_TICK: begin
								pend_q <= pend_q |
									{item.release_request, item.decay_request, 1'b0};
								zero_q <= phase_q == tdadsr_pkg::PH_DISABLED;
							end
							default: ;
						endcase
					end
				end
				tdadsr_pkg::ST_STEP: begin
					case (phase_q)
						tdadsr_pkg::PH_INITIAL: begin
							if (pend_q[tdadsr_pkg::REQ_HANG]) begin
								phase_q <= tdadsr_pkg::PH_HANG;
							end else begin
								pos_q   <= '0;
								phase_q <= tdadsr_pkg::PH_LOOP;
							end
						end
						tdadsr_pkg::PH_START: begin
							pos_q   <= '0;
							phase_q <= tdadsr_pkg::PH_LOOP;
						end
						default: ;
					endcase
				end
				tdadsr_pkg::ST_LOAD: begin
					if (ent_disable)
						phase_q <= tdadsr_pkg::PH_DISABLED;
					else if (ent_hang)
						phase_q <= tdadsr_pkg::PH_HANG;
					else if (ent_restart)
						phase_q <= tdadsr_pkg::PH_INITIAL;
				end
				tdadsr_pkg::ST_GOTO: begin
					if (div_rsp.done)
						pos_q <= div_rsp.rem[AW-1:0];
				end
				tdadsr_pkg::ST_RAMP: begin
					if (div_rsp.done) begin
						ramp_q  <= ramp_new;
						ticks_q <= n_q;
						phase_q <= tdadsr_pkg::PH_FADE;
						pos_q   <= pos_next;
					end
				end
				tdadsr_pkg::ST_FADE: begin
					level_q <= fade_lv;
					ticks_q <= ticks_dec;
					if (ticks_dec == 17'd0)
						phase_q <= tdadsr_pkg::PH_LOOP;
				end
				tdadsr_pkg::ST_DR: begin
					if (cfg.sustain_level != 31'd0 && phase_q == tdadsr_pkg::PH_DECAY) begin
						if (sus_hit) begin
							level_q <= {1'b0, cfg.sustain_level};
							ticks_q <= tdadsr_pkg::SUS_TICKS;
							phase_q <= tdadsr_pkg::PH_SUSTAIN;
						end else begin
							level_q <= dr_lv;
						end
					end else if (dr_lv[31]) begin
						level_q <= '0;
						phase_q <= tdadsr_pkg::PH_DISABLED;
					end else begin
						level_q <= dr_lv;
					end
				end
				tdadsr_pkg::ST_SUS: begin
					ticks_q <= ticks_dec;
					if (ticks_dec == 17'd0)
						phase_q <= tdadsr_pkg::PH_RELEASE;
				end
				tdadsr_pkg::ST_FINISH: begin
					// release beats decay and clears both
					if (pend_q[tdadsr_pkg::REQ_RELEASE]) begin
						phase_q <= tdadsr_pkg::PH_RELEASE;
						pend_q[tdadsr_pkg::REQ_RELEASE] <= 1'b0;
						pend_q[tdadsr_pkg::REQ_DECAY]   <= 1'b0;
					end else if (pend_q[tdadsr_pkg::REQ_DECAY]) begin
						phase_q <= tdadsr_pkg::PH_DECAY;
						pend_q[tdadsr_pkg::REQ_DECAY] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// working values for a table load
	always_ff @(posedge clk) begin
		if (st_q == tdadsr_pkg::ST_LOAD) begin
			n_q  <= n_new;
			sq_q <= sq_full[30:0];
		end
		if (st_q == tdadsr_pkg::ST_TGT && div_rsp.done)
			num_q <= tgt_num;
		if (st_q == tdadsr_pkg::ST_RAMP_GO)
			neg_q <= num_q[32];
	end

	// entry table: one write port, one registered read port
	logic          mem_we;
	logic [AW-1:0] wr_addr;

	assign mem_we  = accept && item.action == tdadsr_pkg::ACT_WRITE &&
		32'(item.entry_index) < TABLE_DEPTH;
	assign wr_addr = AW'(item.entry_index);

	always_ff @(posedge clk) begin
		if (mem_we)
			tbl_mem[wr_addr] <= {item.entry_arg, item.entry_delay};
		if (st_q == tdadsr_pkg::ST_READ)
			rd_q <= tbl_mem[pos_q];
	end

	tdadsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

// ----- rtl/table_driven_adsr_envelope.sv -----
// ----------------------------------------------------------------------------
// table_driven_adsr_envelope : table-driven ADSR envelope generator
// Stream wrapper: register file, input unpacking and the output register.
// ----------------------------------------------------------------------------
// Usage notes
//  - Input stream s_axis: tuser carries the item kind (tick, table write,
//    note start); tdata carries the entry fields and the request flags.
//  - Table writes and note starts are absorbed in the transaction cycle and
//    give no output; the block is ready again on the next cycle.
//  - Each tick gives exactly one m_axis transaction: level (UQ1.15, 0..1.0)
//    and the envelope phase.
//  - Tick path: a disabled envelope goes to EMIT; a hang step passes STEP,
//    FINISH, EMIT; a fade, decay, release or sustain step adds its update
//    state; an entry adds READ and LOAD, then the goto division, or the
//    target and ramp divisions and FADE for a new ramp. Divisions run on the
//    bit-serial divider, one quotient bit per clock (16, 31 and 32 steps).
//  - One item is in flight at a time; s_axis_tready is low from a tick
//    transaction until its result sits in the output register.
//  - Output stall: the result waits in the single output register; the
//    engine holds its next result until that register is free.
//  - Reset clears the envelope state and the registers (updates_per_frame
//    to 1). The entry table is not cleared: write entries before use.
//  - User must write registers via cfg_we/cfg_index/cfg_data only while idle; not enforced.
// ----------------------------------------------------------------------------
module table_driven_adsr_envelope #(
	parameter int TABLE_DEPTH = tdadsr_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave side
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [4:0] entry_index, [20:5] entry_delay, [36:21] entry_arg,
	// [37] hang_request, [38] decay_request, [39] release_request
	input  logic [tdadsr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] action
	input  logic [tdadsr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	// master side
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] level, [19:16] phase, [23:20] zero
	output logic [tdadsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// register write port
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [tdadsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	tdadsr_pkg::item_t item;
	tdadsr_pkg::cfg_t  cfg;
	tdadsr_pkg::res_t  res;

	logic        accept;
	logic        ready;
	logic        out_free;

	// register file
	logic [3:0]  upf_q;
	logic [30:0] sus_q;
	logic [30:0] fade_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upf_q  <= 4'd1;
			sus_q  <= '0;
			fade_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tdadsr_pkg::CFG_UPF:     upf_q  <= cfg_data[3:0];
				tdadsr_pkg::CFG_SUSTAIN: sus_q  <= cfg_data;
				tdadsr_pkg::CFG_FADE:    fade_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.updates_per_frame = upf_q;
	assign cfg.sustain_level     = sus_q;
	assign cfg.fade_out_step     = fade_q;

	// input unpacking
	assign item.action          = s_axis_tuser;
	assign item.entry_index     = s_axis_tdata[4:0];
	assign item.entry_delay     = s_axis_tdata[20:5];
	assign item.entry_arg       = s_axis_tdata[36:21];
	assign item.hang_request    = s_axis_tdata[37];
	assign item.decay_request   = s_axis_tdata[38];
	assign item.release_request = s_axis_tdata[39];

	assign s_axis_tready = ready;
	assign accept        = s_axis_tvalid && ready;

	// output register; frees in the same cycle as its transaction
	logic        out_valid_q;
	logic [15:0] out_level_q;
	logic [3:0]  out_phase_q;

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res.valid)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_level_q <= res.level;
			out_phase_q <= res.phase;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_phase_q, out_level_q};

	tdadsr_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.accept   (accept),
		.ready    (ready),
		.cfg      (cfg),
		.out_free (out_free),
		.res      (res)
	);

endmodule

// ----- rtl/tdadsr_checker.sv -----
// ----------------------------------------------------------------------------
// tdadsr_checker : port-level checks for the envelope generator
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module tdadsr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic [tdadsr_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [tdadsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a tick takes the engine out of idle, so ready drops on the next cycle
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == tdadsr_pkg::ACT_TICK
		|=> !s_axis_tready)
		else $error("ready stayed high after a tick");

	// non-tick items (writes and starts) complete in their own cycle
	a_cfg_item_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser != tdadsr_pkg::ACT_TICK
		|=> s_axis_tready)
		else $error("ready dropped after a non-tick item");

	// level is clamped to 1.0
	a_level_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'h8000)
		else $error("level above 1.0");

endmodule

bind table_driven_adsr_envelope tdadsr_checker u_tdadsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
